// File: rtl/ets_pkg.sv
// shared constants, types and register indexes for the edge trigger capture scaler
// no dependencies; every other file refers to it by scoped names
package ets_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int COLUMNS     = 128;
   localparam int ROWS        = 64;

   // fixed widths of the result fields
   localparam int COL_W = 7;
   localparam int ROW_W = 6;

   localparam int COL_CNT_W = $clog2(COLUMNS);
   localparam int QUOT_W    = $clog2(ROWS);
   localparam int NUM_W     = SAMPLE_BITS + QUOT_W;
   localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_LOW     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_HIGH    = 2'd2;

   localparam logic [SAMPLE_BITS-1:0] TRIGGER_LEVEL_RST = 12'd1552;
   localparam logic [SAMPLE_BITS-1:0] CLAMP_LOW_RST     = 12'd310;
   localparam logic [SAMPLE_BITS-1:0] CLAMP_HIGH_RST    = 12'd2793;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic             capture;
      logic [COL_W-1:0] column;
      logic             last;
   } cap_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: rtl/ets_if.sv
// valid/ready channel interfaces: sample input, scaled result output, register writes
// depends on ets_pkg
interface ets_req_if;
   logic                 valid;
   logic                 ready;
   ets_pkg::sample_type  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface ets_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ets_pkg::COL_W-1:0]   column;
   logic [ets_pkg::ROW_W-1:0]   row;
   logic                        frame_last;

   modport source (output valid, output column, output row, output frame_last, input ready);
   modport sink   (input valid, input column, input row, input frame_last, output ready);
endinterface

interface ets_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ets_pkg::CSR_IDX_W-1:0]   index;
   ets_pkg::sample_type             data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ets_trig.sv
// three-phase rising crossing trigger and frame column counter
// depends on ets_pkg
module ets_trig (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  ets_pkg::sample_type sample,
   input  ets_pkg::sample_type level,
   output ets_pkg::cap_type    cap
);

   localparam int CntW = ets_pkg::COL_CNT_W;
   localparam int ColW = ets_pkg::COL_W;

   localparam logic [1:0] PH_NOT_ABOVE = 2'd0;
   localparam logic [1:0] PH_NOT_BELOW = 2'd1;
   localparam logic [1:0] PH_CAPTURE   = 2'd2;

   localparam logic [CntW-1:0] LastCol = CntW'(ets_pkg::COLUMNS - 1);

   logic [1:0]      phase_ff, phase_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      cap.capture = 1'b0;
      cap.column  = ColW'(count_ff);
      cap.last    = (count_ff == LastCol);
      if (accept) begin
         case (phase_ff)
            PH_NOT_BELOW: begin
               if (sample >= level) begin
                  phase_in = PH_CAPTURE;
                  count_in = '0;
               end
            end
            PH_CAPTURE: begin
               cap.capture = 1'b1;
               if (count_ff == LastCol) begin
                  count_in = '0;
                  phase_in = PH_NOT_ABOVE;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            default: begin
               // unused code acts as the first phase
               phase_in = (sample <= level) ? PH_NOT_BELOW : PH_NOT_ABOVE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NOT_ABOVE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/ets_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on ets_pkg; quotient must fit in QUOT_W bits (numerator < den << QUOT_W)
module ets_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ets_pkg::NUM_W-1:0]         num,
   input  ets_pkg::sample_type               den,
   output ets_pkg::div_stat_type             stat,
   output logic [ets_pkg::QUOT_W-1:0]        quot
);

   localparam int SmpW = ets_pkg::SAMPLE_BITS;
   localparam int QW   = ets_pkg::QUOT_W;
   localparam int NumW = ets_pkg::NUM_W;
   localparam int CntW = ets_pkg::DIV_CNT_W;

   localparam logic [CntW-1:0] LastStep = CntW'(QW - 1);

   logic [SmpW-1:0] rem_ff, rem_in;
   logic [QW-1:0]   shf_ff, shf_in;
   logic [SmpW-1:0] den_ff, den_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;

   logic [SmpW:0]   rem_sh;
   logic [SmpW:0]   rem_sub;
   logic            fits;

   // next numerator bit comes from the top of the shift register,
   // quotient bits enter at the bottom
   assign rem_sh  = {rem_ff, shf_ff[QW-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign fits    = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num[NumW-1:QW];
         shf_in  = num[QW-1:0];
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[SmpW-1:0] : rem_sh[SmpW-1:0];
         shf_in = QW'({shf_ff, fits});
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = shf_ff;

endmodule

// File: rtl/edge_trigger_capture_scaler.sv
// top level: trigger, clamp and serial row scaling with a registered result beat
// depends on ets_pkg, ets_if, ets_trig, ets_div
//
// Samples that the trigger discards are taken one per cycle while idle, with
// ready held high. A captured sample is accepted, clamped and turned into a
// numerator; the bit-serial divider then forms its row bits one at a time
// (log2 of ROWS of them) and the result is loaded into the output register;
// ready returns as the result is loaded, so the next sample can be accepted
// while that beat still waits. If the result register is still occupied when
// the divider finishes, the block holds until it drains. The row is
// (clamp(s) - clamp_low) * (ROWS - 1) / (clamp_high - clamp_low), truncated,
// and 0 when clamp_high <= clamp_low. Register writes are always ready;
// indexes 0 to 2 select trigger_level, clamp_low and clamp_high.
module edge_trigger_capture_scaler (
   input  logic         clock,
   input  logic         reset,
   ets_req_if.sink      req_if,
   ets_rsp_if.source    rsp_if,
   ets_csr_if.sink      csr_if
);

   localparam int SmpW = ets_pkg::SAMPLE_BITS;
   localparam int QW   = ets_pkg::QUOT_W;
   localparam int NumW = ets_pkg::NUM_W;
   localparam int ColW = ets_pkg::COL_W;
   localparam int RowW = ets_pkg::ROW_W;

   localparam logic [QW-1:0] RowMax = QW'(ets_pkg::ROWS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   ets_pkg::sample_type   level_ff, level_in;
   ets_pkg::sample_type   low_ff, low_in;
   ets_pkg::sample_type   high_ff, high_in;

   logic [1:0]            st_ff, st_in;
   logic [ColW-1:0]       col_ff, col_in;
   logic                  last_ff, last_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ColW-1:0]       rsp_col_ff, rsp_col_in;
   logic [RowW-1:0]       rsp_row_ff, rsp_row_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  start;
   logic                  out_free;
   logic                  load;
   logic                  empty;
   ets_pkg::sample_type   s_cl;
   ets_pkg::sample_type   diff;
   logic [NumW-1:0]       num;
   ets_pkg::sample_type   den;

   ets_pkg::cap_type      cap;
   ets_pkg::div_stat_type dstat;
   logic [QW-1:0]         quot;

   // register writes
   assign csr_if.ready = 1'b1;

   always_comb begin
      level_in = level_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            ets_pkg::CSR_TRIGGER_LEVEL: level_in = csr_if.data;
            ets_pkg::CSR_CLAMP_LOW:     low_in   = csr_if.data;
            ets_pkg::CSR_CLAMP_HIGH:    high_in  = csr_if.data;
            default: ;
         endcase
      end
   end

   assign req_if.ready = (st_ff == ST_IDLE);
   assign accept       = req_if.valid & req_if.ready;
   assign start        = accept & cap.capture;

   ets_trig u_trig (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sample (req_if.sample),
      .level  (level_ff),
      .cap    (cap)
   );

   // clamp and numerator; an empty window divides zero by one
   assign empty = (high_ff <= low_ff);
   assign s_cl  = (req_if.sample < low_ff)  ? low_ff  :
                  (req_if.sample > high_ff) ? high_ff : req_if.sample;
   assign diff  = s_cl - low_ff;
   assign num   = empty ? '0 : (NumW'(diff) * NumW'(RowMax));
   assign den   = empty ? SmpW'(1) : (high_ff - low_ff);

   ets_div u_div (
      .clock (clock),
      .reset (reset),
      .start (start),
      .num   (num),
      .den   (den),
      .stat  (dstat),
      .quot  (quot)
   );

   assign out_free = ~rsp_valid_ff | rsp_if.ready;
   assign load     = (((st_ff == ST_DIV) & dstat.done) | (st_ff == ST_WAIT)) & out_free;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (start) st_in = ST_DIV;
         ST_DIV: begin
            if (dstat.done) begin
               st_in = out_free ? ST_IDLE : ST_WAIT;
            end
         end
         ST_WAIT: if (out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   assign col_in  = start ? cap.column : col_ff;
   assign last_in = start ? cap.last   : last_ff;

   assign rsp_valid_in = load | (rsp_valid_ff & ~rsp_if.ready);
   assign rsp_col_in   = load ? col_ff         : rsp_col_ff;
   assign rsp_row_in   = load ? RowW'(quot)    : rsp_row_ff;
   assign rsp_last_in  = load ? last_ff        : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= ets_pkg::TRIGGER_LEVEL_RST;
         low_ff       <= ets_pkg::CLAMP_LOW_RST;
         high_ff      <= ets_pkg::CLAMP_HIGH_RST;
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      last_ff     <= last_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.column     = rsp_col_ff;
   assign rsp_if.row        = rsp_row_ff;
   assign rsp_if.frame_last = rsp_last_ff;

endmodule

// File: rtl/ets_chk.sv
// port-level checker for edge_trigger_capture_scaler, attached by bind
// depends on ets_pkg
module ets_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [ets_pkg::COL_W-1:0] rsp_column,
   input logic [ets_pkg::ROW_W-1:0] rsp_row,
   input logic                      rsp_frame_last
);

   localparam int ColW = ets_pkg::COL_W;
   localparam logic [ColW-1:0] LastCol = ColW'(ets_pkg::COLUMNS - 1);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_column) && $stable(rsp_row)
         && $stable(rsp_frame_last))
      else $error("stalled result beat changed");

   // frame end flag only on the last column
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_last == (rsp_column == LastCol)))
      else $error("frame_last does not match column");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // a fresh result always follows a busy period with the input closed
   a_rise_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a scaling pass");

   // handshake outputs are known whenever a sample is offered
   a_req_ready_known: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> !$isunknown(req_ready) && !$isunknown(rsp_valid))
      else $error("input channel check failed");

endmodule

bind edge_trigger_capture_scaler ets_chk u_ets_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_column     (rsp_if.column),
   .rsp_row        (rsp_if.row),
   .rsp_frame_last (rsp_if.frame_last)
);
